/* rtl/smct_pkg.sv */
package smct_pkg;

    localparam int MaxDim = 4096;
    localparam int DimW = 13;
    localparam int PosW = 12;
    localparam int IdxW = 24;

    typedef enum logic [2:0] {
        CFG_ROW_MAJOR   = 3'd0,
        CFG_TRANSPOSE   = 3'd1,
        CFG_ROW_COUNT   = 3'd2,
        CFG_COL_COUNT   = 3'd3,
        CFG_SCALE       = 3'd4,
        CFG_SRC_STRIDE  = 3'd5,
        CFG_DST_STRIDE  = 3'd6
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_ROWS       = 3'd1,
        ERR_COLS       = 3'd2,
        ERR_SRC_STRIDE = 3'd3,
        ERR_DST_STRIDE = 3'd4
    } err_t;

    localparam logic [31:0] FpOne = 32'h3F80_0000;

endpackage

/* rtl/smct_fmul.sv */
module smct_fmul (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] p
);
    import smct_pkg::*;

    logic        sa, sb, sp;
    logic [7:0]  ea, eb;
    logic [22:0] fa, fb;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [23:0] ma, mb;
    logic [47:0] prod;
    logic [9:0]  za, zb;
    logic signed [11:0] exp_raw;

    // stage 1 registers
    logic        special_reg;
    logic [31:0] special_val_reg;
    logic        sp_reg;
    logic [47:0] prod_reg;
    logic signed [11:0] exp_reg;

    logic        special_next;
    logic [31:0] special_val_next;

    function automatic logic [4:0] lzc24(input logic [23:0] v);
        logic [4:0] n;
        logic       found;
        n = 5'd24;
        found = 1'b0;
        for (int i = 23; i >= 0; i--)
        begin
            if (!found && v[i])
            begin
                n = 5'(23 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    always_comb
    begin
        sa = a[31];
        sb = b[31];
        ea = a[30:23];
        eb = b[30:23];
        fa = a[22:0];
        fb = b[22:0];
        sp = sa ^ sb;
        a_nan = (ea == 8'hFF) && (fa != 23'd0);
        b_nan = (eb == 8'hFF) && (fb != 23'd0);
        a_inf = (ea == 8'hFF) && (fa == 23'd0);
        b_inf = (eb == 8'hFF) && (fb == 23'd0);
        a_zero = (ea == 8'd0) && (fa == 23'd0);
        b_zero = (eb == 8'd0) && (fb == 23'd0);
        ma = {(ea != 8'd0), fa};
        mb = {(eb != 8'd0), fb};
        za = {5'd0, lzc24(ma)};
        zb = {5'd0, lzc24(mb)};
        // normalise subnormal inputs so the product's top bit sits at 46 or 47
        ma = ma << za[4:0];
        mb = mb << zb[4:0];
        prod = ma * mb;
        exp_raw = 12'($signed({4'd0, (ea == 8'd0) ? 8'd1 : ea}))
                + 12'($signed({4'd0, (eb == 8'd0) ? 8'd1 : eb}))
                - 12'sd127 - 12'($signed({2'd0, za})) - 12'($signed({2'd0, zb}));
        special_next = 1'b1;
        if (a_nan)
            special_val_next = a | 32'h0040_0000;
        else if (b_nan)
            special_val_next = b | 32'h0040_0000;
        else if ((a_inf && b_zero) || (b_inf && a_zero))
            special_val_next = 32'hFFC0_0000;
        else if (a_inf || b_inf)
            special_val_next = {sp, 8'hFF, 23'd0};
        else if (a_zero || b_zero)
            special_val_next = {sp, 31'd0};
        else
        begin
            special_next = 1'b0;
            special_val_next = 32'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            special_reg <= special_next;
            special_val_reg <= special_val_next;
            sp_reg <= sp;
            prod_reg <= prod;
            exp_reg <= exp_raw;
        end
    end

    // stage 2: normalise, denormalise, round
    logic [47:0] m;
    logic signed [11:0] e;
    logic [11:0] rsh;
    logic [49:0] wide;
    logic [23:0] keep;
    logic        g, st, inc;
    logic [24:0] rnd;
    logic [7:0]  ef;
    logic [31:0] res;

    always_comb
    begin
        m = prod_reg;
        e = exp_reg;
        if (m[47])
            e = e + 12'sd1;
        else
            m = m << 1;
        // m[47] is leading one, value = m * 2^(e-127-47)
        rsh = 12'd0;
        if (e < 12'sd1)
            rsh = 12'(12'sd1 - e);
        wide = {m, 2'b00};
        if (rsh > 12'd49)
            wide = {49'd0, (m != 48'd0)};
        else
            wide = ({m, 2'b00} >> rsh[5:0])
                 | 50'(((({m, 2'b00} << (6'd50 - rsh[5:0])) != 50'd0) && rsh != 12'd0));
        keep = wide[49:26];
        g = wide[25];
        st = (wide[24:0] != 25'd0);
        inc = g && (st || keep[0]);
        rnd = {1'b0, keep} + {24'd0, inc};
        if (e < 12'sd1)
            ef = rnd[23] ? 8'd1 : 8'd0;
        else
            ef = 8'(e);
        res = 32'd0;
        if (rnd[24])
        begin
            if (e >= 12'sd254)
                res = {sp_reg, 8'hFF, 23'd0};
            else
                res = {sp_reg, 8'(e + 12'sd1), rnd[23:1]};
        end
        else if (e >= 12'sd255)
            res = {sp_reg, 8'hFF, 23'd0};
        else
            res = {sp_reg, ef, rnd[22:0]};
        p = special_reg ? special_val_reg : res;
    end

endmodule

/* rtl/scaled_matrix_copy_transpose.sv */
// each accepted item moves through the stage 1 and stage 2 registers in order
// throughput: one item per cycle, unless out_ready stalls the float multiplier
// reset: registers take their documented defaults (1x1 matrix, scale 1.0),
// position counters clear, pipeline empties

module scaled_matrix_copy_transpose (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] element,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [23:0] dest_index,
    output logic [31:0] value,
    output logic        write_valid,
    output logic        last,
    output logic [2:0]  error_code,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import smct_pkg::*;

    logic            row_major_reg, transpose_reg;
    logic [DimW-1:0] row_count_reg, col_count_reg, src_stride_reg, dst_stride_reg;
    logic [31:0]     scale_reg;
    logic [PosW-1:0] inner_reg, outer_reg;

    logic            v1_reg, v2_reg;
    logic            adv;
    logic [DimW-1:0] inner_len, outer_len, run_len;
    err_t            err;
    logic            inner_end, outer_end;
    logic [IdxW-1:0] idx;
    logic            cfg_hit, in_fire;

    // stage 1 and 2 side fields
    logic [IdxW-1:0] idx1_reg, idx2_reg;
    logic            last1_reg, last2_reg;
    err_t            err1_reg, err2_reg;
    logic            mode0_1_reg, mode1_1_reg, mode0_2_reg, mode1_2_reg;
    logic [31:0]     elem1_reg, elem2_reg;
    logic [31:0]     prod;
    logic [31:0]     prod2_reg;
    logic            a_zero, a_one;

    assign adv = !v2_reg || out_ready;
    assign in_ready = adv;
    assign cfg_ready = 1'b1;
    assign in_fire = in_valid && in_ready;
    assign cfg_hit = cfg_valid && (cfg_index <= CFG_DST_STRIDE);

    always_comb
    begin
        inner_len = row_major_reg ? col_count_reg : row_count_reg;
        outer_len = row_major_reg ? row_count_reg : col_count_reg;
        run_len = transpose_reg ? outer_len : inner_len;
        err = ERR_NONE;
        if (row_count_reg == '0 || row_count_reg > DimW'(MaxDim))
            err = ERR_ROWS;
        else if (col_count_reg == '0 || col_count_reg > DimW'(MaxDim))
            err = ERR_COLS;
        else if (src_stride_reg < inner_len)
            err = ERR_SRC_STRIDE;
        if (dst_stride_reg < run_len)
            err = ERR_DST_STRIDE;
        inner_end = ({1'b0, inner_reg} + 13'd1) >= inner_len;
        outer_end = ({1'b0, outer_reg} + 13'd1) >= outer_len;
        if (transpose_reg)
            idx = ({12'd0, inner_reg} * {11'd0, dst_stride_reg}) + {12'd0, outer_reg};
        else
            idx = ({12'd0, outer_reg} * {11'd0, dst_stride_reg}) + {12'd0, inner_reg};
        a_zero = (scale_reg[30:0] == 31'd0);
        a_one = (scale_reg == FpOne);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_major_reg <= 1'b0;
            transpose_reg <= 1'b0;
            row_count_reg <= DimW'(1);
            col_count_reg <= DimW'(1);
            scale_reg <= FpOne;
            src_stride_reg <= DimW'(1);
            dst_stride_reg <= DimW'(1);
            inner_reg <= '0;
            outer_reg <= '0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                v1_reg <= in_fire;
                v2_reg <= v1_reg;
            end
            if (cfg_hit)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_ROW_MAJOR:  row_major_reg <= cfg_data[0];
                    CFG_TRANSPOSE:  transpose_reg <= cfg_data[0];
                    CFG_ROW_COUNT:  row_count_reg <= cfg_data[DimW-1:0];
                    CFG_COL_COUNT:  col_count_reg <= cfg_data[DimW-1:0];
                    CFG_SCALE:      scale_reg <= cfg_data;
                    CFG_SRC_STRIDE: src_stride_reg <= cfg_data[DimW-1:0];
                    CFG_DST_STRIDE: dst_stride_reg <= cfg_data[DimW-1:0];
                    default:        scale_reg <= scale_reg;
                endcase
                inner_reg <= '0;
                outer_reg <= '0;
            end
            else if (in_fire && err == ERR_NONE)
            begin
                if (inner_end)
                begin
                    inner_reg <= '0;
                    outer_reg <= outer_end ? '0 : outer_reg + PosW'(1);
                end
                else
                    inner_reg <= inner_reg + PosW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            idx1_reg <= (err == ERR_NONE) ? idx : '0;
            last1_reg <= (err == ERR_NONE) && inner_end && outer_end;
            err1_reg <= err;
            mode0_1_reg <= a_zero;
            mode1_1_reg <= a_one;
            elem1_reg <= element;
            idx2_reg <= idx1_reg;
            last2_reg <= last1_reg;
            err2_reg <= err1_reg;
            mode0_2_reg <= mode0_1_reg;
            mode1_2_reg <= mode1_1_reg;
            elem2_reg <= elem1_reg;
            prod2_reg <= prod;
        end
    end

    smct_fmul u_fmul (
        .clk (clk),
        .en  (adv),
        .a   (scale_reg),
        .b   (element),
        .p   (prod)
    );

    assign out_valid = v2_reg;
    assign dest_index = idx2_reg;
    assign last = last2_reg;
    assign error_code = err2_reg;
    assign write_valid = (err2_reg == ERR_NONE);
    assign value = (err2_reg != ERR_NONE) ? 32'd0 :
                   mode0_2_reg ? 32'd0 :
                   mode1_2_reg ? elem2_reg : prod2_reg;

`ifndef SYNTH
    a_err_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code != ERR_NONE |-> !write_valid && !last && value == 32'd0)
        else $error("error item carries a write");
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(dest_index))
        else $error("stalled result changed");
    a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_hit |=> inner_reg == '0 && outer_reg == '0)
        else $error("counters not cleared by write");
`endif

endmodule
